>>> sv/vlm_pkg.sv
// Shared types and constants for the vibration level meter.
package vlm_pkg;

    localparam int HISTORY_DEPTH = 16;

    localparam int AXIS_W  = 16;
    localparam int AXES    = 3;
    localparam int SQ_W    = 2 * AXIS_W;
    localparam int SQRT_W  = SQ_W / 2;
    localparam int REM_W   = SQRT_W + 4;
    localparam int MAG_W   = 17;
    localparam int CFG_W   = 8;
    localparam int SUM_W   = 24;
    localparam int LEVEL_W = 19;

    localparam int HIDX_W  = $clog2(HISTORY_DEPTH);
    localparam int AVG_DIV = HISTORY_DEPTH + 1;
    localparam int ACC_W   = MAG_W + $clog2(AVG_DIV);
    localparam int REP_DIV = 50;

    localparam int MUL_AW  = SUM_W;
    localparam int MUL_BW  = 20;
    localparam int PROD_W  = MUL_AW + MUL_BW;

    localparam int AVG_K     = ACC_W;
    localparam int AVG_RECIP = (2 ** AVG_K) / AVG_DIV;
    localparam int REP_K     = SUM_W;
    localparam int REP_RECIP = (2 ** REP_K) / REP_DIV;

    localparam int SQRT_STEPS = SQRT_W;
    localparam int CNT_W      = $clog2(SQRT_STEPS + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(20);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_AVG_MUL,
        ST_AVG_BACK,
        ST_AVG_FIX,
        ST_UPDATE,
        ST_REP_MUL,
        ST_REP_BACK,
        ST_REP_FIX
    } t_state;

endpackage

>>> sv/vibration_level_meter.sv
// Vibration level meter: magnitude, moving average and deviation report.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------
//  input     | i_in_valid / o_in_stall    | i_accel_x, i_accel_y, i_accel_z
//  output    | o_out_valid / i_out_stall  | o_vibration_level
//  config    | i_cfg_we                   | i_cfg_data
//
// Most of the work on a sample, from its beat to the return of ready, lies in
// the 16-step bit-pair square root; a reporting sample also passes the report states.
// One shared multiplier forms the squares and both reciprocal divisions.
// The history sum over 15 entries runs alongside the squaring and the root.
// Reset clears the history, counter, sum and output valid, and loads a report threshold of 20.
// A report waits while the previous result is still held by a stalled output.
module vibration_level_meter
    import vlm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [AXIS_W-1:0]  i_accel_x,
    input  logic signed [AXIS_W-1:0]  i_accel_y,
    input  logic signed [AXIS_W-1:0]  i_accel_z,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [LEVEL_W-1:0]        o_vibration_level,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    localparam logic [HIDX_W-1:0] HIST_LAST = HIDX_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0]  SQ_LAST   = CNT_W'(AXES);
    localparam logic [CNT_W-1:0]  ROOT_LAST = CNT_W'(SQRT_STEPS);

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_cfg;
    logic [AXIS_W-1:0]  r_abs [AXES];
    logic [CNT_W-1:0]   r_cnt;
    logic [SQ_W-1:0]    r_sq;
    logic [REM_W-1:0]   r_rem;
    logic [SQRT_W-1:0]  r_root;
    logic [MAG_W-1:0]   r_hist [HISTORY_DEPTH];
    logic [HIDX_W-1:0]  r_hidx;
    logic [ACC_W-1:0]   r_hsum;
    logic [ACC_W-1:0]   r_acc;
    logic [PROD_W-1:0]  r_prod;
    logic [MUL_AW-1:0]  r_q;
    logic [MAG_W-1:0]   r_avg;
    logic [CFG_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_sum;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_level;

    logic               hist_done;
    logic               in_beat;
    logic               out_free;
    logic               report;
    logic [MUL_AW-1:0]  mul_a;
    logic [MUL_BW-1:0]  mul_b;
    logic [PROD_W-1:0]  product;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic [MAG_W-1:0]   mag;
    logic [ACC_W-1:0]   acc;
    logic [MUL_AW-1:0]  avg_rem;
    logic [MUL_AW-1:0]  avg_q;
    logic [MUL_AW-1:0]  rep_rem;
    logic [MUL_AW-1:0]  rep_q;
    logic [MAG_W-1:0]   dev;
    logic [SUM_W:0]     sum_ext;

    function automatic logic [AXIS_W-1:0] abs16(input logic signed [AXIS_W-1:0] v);
        logic [AXIS_W-1:0] u;
        u = v;
        return v[AXIS_W-1] ? (~u + AXIS_W'(1)) : u;
    endfunction

    assign hist_done = (r_hidx == HIST_LAST);
    assign in_beat   = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign report    = (r_count >= r_cfg);

    assign rem_sh  = {r_rem[REM_W-3:0], r_sq[SQ_W-1 -: 2]};
    assign trial   = REM_W'({r_root, 2'b01});
    assign mag     = MAG_W'(r_root);
    assign acc     = r_hsum + ACC_W'({mag, 1'b0});
    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign avg_rem = MUL_AW'(r_acc) - r_prod[MUL_AW-1:0];
    assign avg_q   = r_q + MUL_AW'(avg_rem >= MUL_AW'(AVG_DIV));
    assign rep_rem = MUL_AW'(r_sum) - r_prod[MUL_AW-1:0];
    assign rep_q   = r_q + MUL_AW'(rep_rem >= MUL_AW'(REP_DIV));

    assign dev     = (mag >= r_avg) ? (mag - r_avg) : (r_avg - mag);
    assign sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(dev);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_SQUARE;
            ST_SQUARE:   if (r_cnt == SQ_LAST) n_state = ST_ROOT;
            ST_ROOT:     if (r_cnt == ROOT_LAST && hist_done) n_state = ST_AVG_MUL;
            ST_AVG_MUL:  n_state = ST_AVG_BACK;
            ST_AVG_BACK: n_state = ST_AVG_FIX;
            ST_AVG_FIX:  n_state = ST_UPDATE;
            ST_UPDATE:   n_state = report ? ST_REP_MUL : ST_IDLE;
            ST_REP_MUL:  n_state = ST_REP_BACK;
            ST_REP_BACK: n_state = ST_REP_FIX;
            ST_REP_FIX:  if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        mul_a      = '0;
        mul_b      = '0;
        unique case (r_state)
            ST_SQUARE: begin
                case (r_cnt)
                    CNT_W'(0): mul_a = MUL_AW'(r_abs[0]);
                    CNT_W'(1): mul_a = MUL_AW'(r_abs[1]);
                    CNT_W'(2): mul_a = MUL_AW'(r_abs[2]);
                    default:   mul_a = '0;
                endcase
                mul_b = MUL_BW'(mul_a);
            end
            ST_AVG_MUL: begin
                mul_a = MUL_AW'(acc);
                mul_b = MUL_BW'(AVG_RECIP);
            end
            ST_AVG_BACK: begin
                mul_a = MUL_AW'(r_prod >> AVG_K);
                mul_b = MUL_BW'(AVG_DIV);
            end
            ST_REP_MUL: begin
                mul_a = r_sum;
                mul_b = MUL_BW'(REP_RECIP);
            end
            ST_REP_BACK: begin
                mul_a = MUL_AW'(r_prod >> REP_K);
                mul_b = MUL_BW'(REP_DIV);
            end
            ST_REP_FIX: begin
                mul_a = r_q;
                mul_b = MUL_BW'(REP_DIV);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= CFG_RESET;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_hidx      <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (r_state == ST_REP_FIX && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_cnt  <= '0;
                        r_hidx <= '0;
                    end
                end
                ST_SQUARE: begin
                    r_cnt <= (r_cnt == SQ_LAST) ? '0 : r_cnt + CNT_W'(1);
                    if (!hist_done) r_hidx <= r_hidx + HIDX_W'(1);
                end
                ST_ROOT: begin
                    if (r_cnt != ROOT_LAST) r_cnt <= r_cnt + CNT_W'(1);
                    if (!hist_done) r_hidx <= r_hidx + HIDX_W'(1);
                end
                ST_UPDATE: begin
                    for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                        r_hist[i] <= r_hist[i-1];
                    end
                    r_hist[0] <= mag;
                    if (report) begin
                        r_count <= '0;
                    end else begin
                        r_count <= r_count + CFG_W'(1);
                        r_sum   <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                    end
                end
                ST_REP_FIX: begin
                    if (out_free) r_sum <= '0;
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= product;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    r_abs[0] <= abs16(i_accel_x);
                    r_abs[1] <= abs16(i_accel_y);
                    r_abs[2] <= abs16(i_accel_z);
                    r_sq     <= '0;
                    r_rem    <= '0;
                    r_root   <= '0;
                    r_hsum   <= '0;
                end
            end
            ST_SQUARE: begin
                if (r_cnt != CNT_W'(0)) r_sq <= r_sq + r_prod[SQ_W-1:0];
                if (!hist_done) r_hsum <= r_hsum + ACC_W'(r_hist[r_hidx]);
            end
            ST_ROOT: begin
                if (r_cnt != ROOT_LAST) begin
                    r_sq <= r_sq << 2;
                    if (rem_sh >= trial) begin
                        r_rem  <= rem_sh - trial;
                        r_root <= {r_root[SQRT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_root <= {r_root[SQRT_W-2:0], 1'b0};
                    end
                end
                if (!hist_done) r_hsum <= r_hsum + ACC_W'(r_hist[r_hidx]);
            end
            ST_AVG_MUL: begin
                r_acc <= acc;
            end
            ST_AVG_BACK: begin
                r_q <= MUL_AW'(r_prod >> AVG_K);
            end
            ST_AVG_FIX: begin
                r_avg <= MAG_W'(avg_q);
            end
            ST_REP_BACK: begin
                r_q <= MUL_AW'(r_prod >> REP_K);
            end
            ST_REP_FIX: begin
                if (out_free) r_level <= LEVEL_W'(rep_q);
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_vibration_level = r_level;

endmodule

>>> sv/vlm_checker.sv
// Port-level checker for the vibration level meter, with its bind.
module vlm_checker
    import vlm_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [LEVEL_W-1:0] o_vibration_level
);

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(((2 ** SUM_W) - 1) / REP_DIV);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Output beat dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_vibration_level))
        else $error("Output payload changed while stalled.");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Input taken while a sample is still in work.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid survived reset.");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_vibration_level <= LEVEL_MAX)
        else $error("Reported level exceeds the largest possible value.");

endmodule

bind vibration_level_meter vlm_checker u_vlm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_vibration_level (o_vibration_level)
);
